>>> hdl/lzss_token_bitstream_encoder_unit_macros.svh
// Assertion macros for the LZSS token encoder unit.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef LZSS_TOKEN_BITSTREAM_ENCODER_UNIT_MACROS_SVH
`define LZSS_TOKEN_BITSTREAM_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication.
`define LZSS_TBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LZSS_TBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/lzss_tbe_pkg.sv
// Shared types and constants for the LZSS token encoder.
// No dependencies.
package lzss_tbe_pkg;

  localparam int DescW   = 8;                      // descriptor register width
  localparam int CodeW   = 7;                      // widest descriptor code
  localparam int MaxRes  = 5;                      // results per token, max
  localparam int NumW    = $clog2(MaxRes + 1);
  localparam int IdxW    = $clog2(MaxRes);

  localparam logic [CodeW-1:0] EndCode = 7'h23;    // terminator code

  typedef enum logic [1:0] {
    TOK_LIT   = 2'd0,
    TOK_MATCH = 2'd1,
    TOK_END   = 2'd2
  } tok_kind_e;

  typedef enum logic [1:0] {
    STR_DESC = 2'd0,
    STR_DATA = 2'd1,
    STR_HDR  = 2'd2
  } stream_kind_e;

  typedef struct packed {
    logic [1:0]  token_kind;
    logic [7:0]  literal_byte;
    logic [10:0] match_distance;
    logic [7:0]  match_length;
  } tok_t;

  typedef struct packed {
    logic [1:0]  stream_kind;
    logic [15:0] byte_value;
  } res_item_t;

  // One classified token: its results in order, item[0] first.
  typedef struct packed {
    logic [NumW-1:0]              num;
    res_item_t [MaxRes-1:0]       item;
  } job_t;

endpackage

>>> hdl/lzss_tbe_if.sv
// Token and result channel interfaces (valid/ready).
// Depends on nothing; payload fields are plain logic.
interface lzss_tbe_tok_if;
  logic        valid;
  logic        ready;
  logic [1:0]  token_kind;
  logic [7:0]  literal_byte;
  logic [10:0] match_distance;
  logic [7:0]  match_length;

  modport source (output valid, token_kind, literal_byte, match_distance, match_length,
                  input ready);
  modport sink   (input valid, token_kind, literal_byte, match_distance, match_length,
                  output ready);
endinterface

interface lzss_tbe_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  stream_kind;
  logic [15:0] byte_value;
  logic        last_of_run;

  modport source (output valid, stream_kind, byte_value, last_of_run, input ready);
  modport sink   (input valid, stream_kind, byte_value, last_of_run, output ready);
endinterface

>>> hdl/lzss_tbe_queue.sv
// Small job queue between the token front end and the result sequencer.
// Depends on lzss_tbe_pkg.
module lzss_tbe_queue import lzss_tbe_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_q + 1'b1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

>>> hdl/lzss_tbe_front.sv
// Front end: takes tokens, packs descriptor codes, builds result jobs.
// Depends on lzss_tbe_pkg.
module lzss_tbe_front import lzss_tbe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic tok_valid_i,
  input  tok_t tok_i,
  output logic tok_ready_o,
  input  logic q_ready_i,
  output logic push_o,
  output job_t job_o
);

  logic [DescW-1:0] shift_q, shift_d;
  logic [3:0]       bl_q, bl_d;
  logic [15:0]      cnt_q, cnt_d;

  logic             accept, known, is_end;
  logic [CodeW-1:0] code_al;    // code left-aligned in CodeW bits
  logic [2:0]       code_cnt;
  logic [14:0]      win, win_e, win_s, win_f;
  logic             emit;
  logic [7:0]       desc_byte, shift_new, flush_byte;
  logic [3:0]       bl_new;
  logic [15:0]      cnt_new, cnt_end;
  logic [2:0]       hi;
  logic             len2, len3, len4, len5, near;
  res_item_t [3:0]  tail;
  logic [NumW-1:0]  tail_n;

  assign tok_ready_o = q_ready_i;
  assign accept      = tok_valid_i && q_ready_i;
  assign push_o      = accept && known;

  assign hi   = tok_i.match_distance[10:8];
  assign near = (hi == 3'd0);
  assign len2 = (tok_i.match_length == 8'd2);
  assign len3 = (tok_i.match_length == 8'd3);
  assign len4 = (tok_i.match_length == 8'd4);
  assign len5 = (tok_i.match_length == 8'd5);

  // code selection and data bytes that follow
  always_comb begin
    known    = 1'b1;
    is_end   = 1'b0;
    code_al  = '0;
    code_cnt = 3'd1;
    tail     = '0;
    tail_n   = '0;
    case (tok_i.token_kind)
      TOK_LIT: begin
        code_al  = 7'b100_0000;
        code_cnt = 3'd1;
        tail[0]  = '{STR_DATA, {8'h00, tok_i.literal_byte}};
        tail_n   = NumW'(1);
      end
      TOK_MATCH: begin
        tail[0] = '{STR_DATA, {8'h00, tok_i.match_distance[7:0]}};
        tail_n  = NumW'(1);
        if ((len2 || len3) && near) begin
          code_al  = {2'b00, len3, 4'b0000};
          code_cnt = 3'd3;
        end else if (len3 || len4 || len5) begin
          code_al  = {2'b01, hi, len5, len4};
          code_cnt = 3'd7;
        end else begin
          code_al  = {2'b01, hi, 2'b11};
          code_cnt = 3'd7;
          tail[1]  = '{STR_DATA, {8'h00, tok_i.match_length}};
          tail_n   = NumW'(2);
        end
      end
      TOK_END: begin
        is_end   = 1'b1;
        code_al  = EndCode;
        code_cnt = 3'd7;
        tail[0]  = '{STR_DESC, {8'h00, flush_byte}};
        tail[1]  = '{STR_HDR, cnt_end};
        tail[2]  = '{STR_DATA, 16'h0000};
        tail[3]  = '{STR_DATA, 16'h0000};
        tail_n   = NumW'(4);
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // register packing: a full register goes out before the bit that overflows it
  always_comb begin
    win        = {shift_q, code_al};
    emit       = ({1'b0, code_cnt} > bl_q);
    win_e      = win >> (3'd7 - bl_q[2:0]);
    desc_byte  = win_e[7:0];
    win_s      = win >> (3'd7 - code_cnt);
    shift_new  = win_s[7:0];
    bl_new     = emit ? 4'(bl_q + 4'd8 - {1'b0, code_cnt}) : 4'(bl_q - {1'b0, code_cnt});
    cnt_new    = emit ? 16'(cnt_q + 16'd1) : cnt_q;
    win_f      = {7'b0, shift_new} << bl_new[2:0];
    flush_byte = win_f[7:0];
    cnt_end    = 16'(cnt_new + 16'd1);
  end

  // job assembly: optional descriptor byte, then the tail
  always_comb begin
    job_o = '0;
    if (emit) begin
      job_o.num     = NumW'(tail_n + 1'b1);
      job_o.item[0] = '{STR_DESC, {8'h00, desc_byte}};
      for (int i = 1; i < MaxRes; i++) begin
        job_o.item[i] = tail[i-1];
      end
    end else begin
      job_o.num = tail_n;
      for (int i = 0; i < MaxRes - 1; i++) begin
        job_o.item[i] = tail[i];
      end
    end
  end

  always_comb begin
    shift_d = shift_q;
    bl_d    = bl_q;
    cnt_d   = cnt_q;
    if (push_o) begin
      if (is_end) begin
        shift_d = '0;
        bl_d    = 4'(DescW);
        cnt_d   = '0;
      end else begin
        shift_d = shift_new;
        bl_d    = bl_new;
        cnt_d   = cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      bl_q    <= 4'(DescW);
      cnt_q   <= '0;
    end else begin
      shift_q <= shift_d;
      bl_q    <= bl_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> hdl/lzss_tbe_back.sv
// Back end: steps through a job's results from a register, one per cycle
// while the result port is ready. Depends on lzss_tbe_pkg.
module lzss_tbe_back import lzss_tbe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  job_t      job_i,
  output logic      pop_o,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output res_item_t res_o,
  output logic      last_o
);

  job_t            job_q, job_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            busy_q, busy_d;
  logic            fire, done, load;

  assign res_valid_o = busy_q;
  assign res_o       = job_q.item[idx_q];
  assign last_o      = (NumW'(idx_q) == NumW'(job_q.num - 1'b1));

  assign fire  = busy_q && res_ready_i;
  assign done  = fire && last_o;
  assign load  = q_valid_i && (!busy_q || done);
  assign pop_o = load;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    job_d  = job_q;
    if (load) begin
      busy_d = 1'b1;
      idx_d  = '0;
      job_d  = job_i;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (fire) begin
      idx_d = IdxW'(idx_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

endmodule

>>> hdl/lzss_token_bitstream_encoder_unit.sv
// LZSS token encoder top: front end -> job queue -> result sequencer.
// A taken token is registered in the queue, then in the back-end job register.
// Throughput: one result per cycle while the result port is ready; a token
//   gives 1 to 5 results (literal/short/mid match 1-2, long match 2-3, end 4-5).
// Reset (async, active low): descriptor register empty, byte count zero, queue empty.
// Uses lzss_tbe_pkg, lzss_tbe_if and the unit's assertion macro header.
`include "lzss_token_bitstream_encoder_unit_macros.svh"

module lzss_token_bitstream_encoder_unit import lzss_tbe_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lzss_tbe_tok_if.sink  tok_i,
  lzss_tbe_res_if.source res_o
);

  // Token payload as one struct for the front end.
  tok_t      tok;
  logic      tok_ready;

  // Front end -> queue
  logic      push;
  job_t      push_job;
  logic      q_ready;

  // Queue -> back end
  logic      q_valid;
  job_t      q_job;
  logic      pop;

  // Back end -> result port
  res_item_t res_item;
  logic      res_valid;
  logic      res_last;

  assign tok = '{token_kind:     tok_i.token_kind,
                 literal_byte:   tok_i.literal_byte,
                 match_distance: tok_i.match_distance,
                 match_length:   tok_i.match_length};
  assign tok_i.ready = tok_ready;

  // Front end owns the descriptor register, its fill level and the
  // descriptor byte count; it turns each token into a full result list.
  // Unknown token kinds are taken and dropped.
  lzss_tbe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_i.valid),
    .tok_i       (tok),
    .tok_ready_o (tok_ready),
    .q_ready_i   (q_ready),
    .push_o      (push),
    .job_o       (push_job)
  );

  // Decouples token intake from the result port.
  lzss_tbe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  // Walks the job, one result per accepted handshake; next job loads on
  // the cycle the last result goes out, so there is no bubble when one waits.
  lzss_tbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .job_i       (q_job),
    .pop_o       (pop),
    .res_valid_o (res_valid),
    .res_ready_i (res_o.ready),
    .res_o       (res_item),
    .last_o      (res_last)
  );

  assign res_o.valid       = res_valid;
  assign res_o.stream_kind = res_item.stream_kind;
  assign res_o.byte_value  = res_item.byte_value;
  assign res_o.last_of_run = res_last;

  // Assertions
  `LZSS_TBE_ASSERT_NOW(a_job_size, push, (push_job.num != '0) && (push_job.num <= NumW'(MaxRes)), "job with bad result count")
  `LZSS_TBE_ASSERT_NEXT(a_no_stall, !res_valid && q_valid, res_valid, "queued job not started")
  `LZSS_TBE_ASSERT_NOW(a_hdr_not_last, res_valid && (res_item.stream_kind == STR_HDR), !res_last, "count header marked last")

endmodule
